FILE: hdl/nat_pkg.sv
// Shared types, codes and checksum helpers for the static IPv4 NAT engine.
// No dependencies; used by the stream interface and the top level.
package nat_pkg;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_XSRC = 2'd1;
  localparam logic [1:0] OP_XDST = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] OFF_NONE = 2'd0;
  localparam logic [1:0] OFF_TCP  = 2'd1;
  localparam logic [1:0] OFF_UDP  = 2'd2;

  localparam logic [1:0] FRAG_NONE  = 2'd0;
  localparam logic [1:0] FRAG_FIRST = 2'd1;
  localparam logic [1:0] FRAG_LATER = 2'd2;
  localparam logic [1:0] FRAG_RSVD  = 2'd3;

  localparam logic [7:0] PROTO_ICMP    = 8'd1;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_UDPLITE = 8'd136;

  localparam logic [7:0] ICMP_UNREACH  = 8'd3;
  localparam logic [7:0] ICMP_TIMEX    = 8'd11;
  localparam logic [7:0] ICMP_PARAMPRB = 8'd12;

  localparam logic [15:0] ICMP_MIN_LEN = 16'd48;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [7:0]  protocol;
    logic [1:0]  fragment_kind;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [7:0]  icmp_kind;
    logic [15:0] outer_length;
    logic [31:0] inner_source;
    logic [31:0] inner_destination;
    logic [15:0] inner_checksum;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_source;
    logic [31:0] new_destination;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_l4_checksum;
    logic [1:0]  offload_request;
    logic [31:0] new_inner_source;
    logic [31:0] new_inner_destination;
    logic [15:0] new_inner_checksum;
    logic [31:0] drop_total;
  } rsp_t;

  function automatic logic [15:0] csum_adj(input logic [15:0] hc, input logic [31:0] oldw,
                                           input logic [31:0] neww);
    logic [18:0] s;
    logic [16:0] s1;
    logic [16:0] s2;
    s  = {3'b000, ~hc} + {3'b000, ~oldw[31:16]} + {3'b000, ~oldw[15:0]}
         + {3'b000, neww[31:16]} + {3'b000, neww[15:0]};
    s1 = 17'(s[15:0]) + 17'(s[18:16]);
    s2 = 17'(s1[15:0]) + 17'(s1[16]);
    return ~s2[15:0];
  endfunction

  function automatic logic [15:0] csum_adj16(input logic [15:0] hc, input logic [15:0] oldh,
                                             input logic [15:0] newh);
    logic [17:0] s;
    logic [16:0] s1;
    logic [16:0] s2;
    s  = {2'b00, ~hc} + {2'b00, ~oldh} + {2'b00, newh};
    s1 = 17'(s[15:0]) + 17'(s[17:16]);
    s2 = 17'(s1[15:0]) + 17'(s1[16]);
    return ~s2[15:0];
  endfunction

endpackage

FILE: hdl/nat_stream_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Depends on nat_pkg for the default payload type.
interface nat_stream_if #(parameter type T = nat_pkg::req_t);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/nat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/nat_address_rewrite_engine.sv
// Static one-to-one IPv4 NAT: hashed rule RAM with linear probing and checksum rewrite.
// Depends on nat_pkg, nat_stream_if and nat_ram. One item at a time: a new request is accepted
// only after the previous result has been loaded, and a held result register stalls that load.
// Each search probes successive slots until a hit, an empty slot or an exhausted table.
// After reset a clearing pass over every slot holds input ready low; drops reset to zero.
module nat_address_rewrite_engine #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nat_stream_if.sink   req_i,
  nat_stream_if.source rsp_o
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int MW = 65;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PROBE = 11'b00000000100,
    S_ACHK  = 11'b00000001000,
    S_CS1   = 11'b00000010000,
    S_CS2   = 11'b00000100000,
    S_CS3   = 11'b00001000000,
    S_DONE  = 11'b00010000000
  } state_e;

  typedef enum logic [2:0] {
    P_ADD_A,
    P_ADD_B1,
    P_ADD_B2,
    P_OUTER,
    P_INNER
  } purp_e;

  function automatic logic [IW-1:0] hash_idx(input logic [31:0] k);
    logic [IW-1:0] h;
    logic [IW:0]   hx;
    h = '0;
    for (int i = 0; i < 32; i++) begin
      h[i % IW] = h[i % IW] ^ k[i];
    end
    hx = {1'b0, h};
    if (hx >= (IW+1)'(TABLE_ENTRIES)) begin
      hx = hx - (IW+1)'(TABLE_ENTRIES);
    end
    return hx[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(TABLE_ENTRIES - 1)) ? '0 : i + IW'(1);
  endfunction

  state_e        state_q, state_d;
  purp_e         purp_q, purp_d;
  nat_pkg::req_t in_q, in_d;
  nat_pkg::rsp_t res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   key_q, key_d;
  logic [IW-1:0] addr_q, addr_d, pa_q, pa_d, exam_q, exam_d, clr_q, clr_d;
  logic          pend_q, pend_d;
  logic          ha_q, ha_d, hb_q, hb_d;
  logic [IW-1:0] sa_q, sa_d;
  logic [IW:0]   cnt_q, cnt_d;
  logic [31:0]   drop_q, drop_d;
  logic [31:0]   newa_q, newa_d, innew_q, innew_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata, rdata;

  logic          start;
  logic [31:0]   skey;
  purp_e         spurp;

  logic          later, l4path, icmp_err, icmp_inner, same_ab;
  logic [31:0]   old_addr, inner_old;
  logic          found, empty, exhausted;
  logic [1:0]    need;
  logic [IW+1:0] fill;

  nat_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_rules (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign later      = in_q.fragment_kind[1];
  assign l4path     = !later && (in_q.protocol == nat_pkg::PROTO_TCP ||
                                 in_q.protocol == nat_pkg::PROTO_UDP ||
                                 in_q.protocol == nat_pkg::PROTO_UDPLITE);
  assign icmp_err   = !later && in_q.protocol == nat_pkg::PROTO_ICMP &&
                      (in_q.icmp_kind == nat_pkg::ICMP_UNREACH ||
                       in_q.icmp_kind == nat_pkg::ICMP_TIMEX ||
                       in_q.icmp_kind == nat_pkg::ICMP_PARAMPRB);
  assign icmp_inner = icmp_err && !l4path && in_q.outer_length >= nat_pkg::ICMP_MIN_LEN;
  assign same_ab    = in_q.addr_a == in_q.addr_b;
  assign old_addr   = (in_q.op == nat_pkg::OP_XSRC) ? in_q.addr_a : in_q.addr_b;
  assign inner_old  = (in_q.op == nat_pkg::OP_XSRC) ? in_q.inner_destination
                                                    : in_q.inner_source;

  assign found     = rdata[64] && rdata[63:32] == key_q;
  assign empty     = !rdata[64];
  assign exhausted = exam_q == IW'(TABLE_ENTRIES - 1);
  assign need      = 2'(!ha_q) + 2'(!same_ab && !hb_q);
  assign fill      = (IW+2)'(cnt_q) + (IW+2)'(need);

  assign req_i.ready = state_q == S_IDLE;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    purp_d      = purp_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    key_d       = key_q;
    addr_d      = addr_q;
    pa_d        = pa_q;
    exam_d      = exam_q;
    pend_d      = pend_q;
    ha_d        = ha_q;
    hb_d        = hb_q;
    sa_d        = sa_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    drop_d      = drop_q;
    newa_d      = newa_q;
    innew_d     = innew_q;
    we          = 1'b0;
    waddr       = clr_q;
    wdata       = '0;
    start       = 1'b0;
    skey        = in_q.addr_a;
    spurp       = P_ADD_A;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = next_idx(clr_q);
        if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          in_d                        = req_i.data;
          res_d.status                = nat_pkg::ST_OK;
          res_d.new_source            = req_i.data.addr_a;
          res_d.new_destination       = req_i.data.addr_b;
          res_d.new_ip_checksum       = req_i.data.ip_checksum;
          res_d.new_l4_checksum       = req_i.data.l4_checksum;
          res_d.offload_request       = nat_pkg::OFF_NONE;
          res_d.new_inner_source      = req_i.data.inner_source;
          res_d.new_inner_destination = req_i.data.inner_destination;
          res_d.new_inner_checksum    = req_i.data.inner_checksum;
          res_d.drop_total            = '0;
          case (req_i.data.op)
            nat_pkg::OP_ADD: begin
              start = 1'b1;
              skey  = req_i.data.addr_a;
              spurp = P_ADD_A;
            end
            nat_pkg::OP_XSRC: begin
              start = 1'b1;
              skey  = req_i.data.addr_a;
              spurp = P_OUTER;
            end
            nat_pkg::OP_XDST: begin
              start = 1'b1;
              skey  = req_i.data.addr_b;
              spurp = P_OUTER;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PROBE: begin
        if (pend_q && (found || empty || exhausted)) begin
          case (purp_q)
            P_ADD_A: begin
              ha_d = found;
              sa_d = pa_q;
              if (same_ab) begin
                state_d = S_ACHK;
              end else begin
                start = 1'b1;
                skey  = in_q.addr_b;
                spurp = P_ADD_B1;
              end
            end
            P_ADD_B1: begin
              hb_d    = found;
              state_d = S_ACHK;
            end
            P_ADD_B2: begin
              we      = 1'b1;
              waddr   = pa_q;
              wdata   = {1'b1, in_q.addr_b, in_q.addr_a};
              cnt_d   = cnt_q + (IW+1)'(!found);
              state_d = S_DONE;
            end
            P_OUTER: begin
              if (!found) begin
                res_d.status = nat_pkg::ST_DROP;
                drop_d       = drop_q + 32'd1;
                state_d      = S_DONE;
              end else begin
                newa_d = rdata[31:0];
                if (icmp_inner) begin
                  start = 1'b1;
                  skey  = inner_old;
                  spurp = P_INNER;
                end else begin
                  state_d = S_CS1;
                end
              end
            end
            P_INNER: begin
              if (!found) begin
                res_d.status = nat_pkg::ST_DROP;
                drop_d       = drop_q + 32'd1;
                state_d      = S_DONE;
              end else begin
                innew_d = rdata[31:0];
                state_d = S_CS1;
              end
            end
            default: state_d = S_DONE;
          endcase
        end else begin
          if (pend_q) begin
            exam_d = exam_q + IW'(1);
          end
          pend_d = 1'b1;
          pa_d   = addr_q;
          addr_d = next_idx(addr_q);
        end
      end
      S_ACHK: begin
        if (fill > (IW+2)'(TABLE_ENTRIES)) begin
          res_d.status = nat_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          we    = 1'b1;
          waddr = sa_q;
          wdata = {1'b1, in_q.addr_a, in_q.addr_b};
          cnt_d = cnt_q + (IW+1)'(!ha_q);
          if (same_ab) begin
            state_d = S_DONE;
          end else begin
            start = 1'b1;
            skey  = in_q.addr_b;
            spurp = P_ADD_B2;
          end
        end
      end
      S_CS1: begin
        if (in_q.op == nat_pkg::OP_XSRC) begin
          res_d.new_source = newa_q;
        end else begin
          res_d.new_destination = newa_q;
        end
        res_d.new_ip_checksum = nat_pkg::csum_adj(in_q.ip_checksum, old_addr, newa_q);
        state_d = S_DONE;
        if (l4path) begin
          if (in_q.fragment_kind == nat_pkg::FRAG_FIRST) begin
            res_d.new_l4_checksum = nat_pkg::csum_adj(in_q.l4_checksum, old_addr, newa_q);
          end else begin
            res_d.new_l4_checksum = '0;
            res_d.offload_request = (in_q.protocol == nat_pkg::PROTO_TCP) ?
                                    nat_pkg::OFF_TCP : nat_pkg::OFF_UDP;
          end
        end else if (icmp_err) begin
          if (!icmp_inner) begin
            res_d.status = nat_pkg::ST_SHORT;
          end else begin
            if (in_q.op == nat_pkg::OP_XSRC) begin
              res_d.new_inner_destination = innew_q;
            end else begin
              res_d.new_inner_source = innew_q;
            end
            res_d.new_inner_checksum = nat_pkg::csum_adj(in_q.inner_checksum, inner_old,
                                                         innew_q);
            state_d = S_CS2;
          end
        end
      end
      S_CS2: begin
        res_d.new_l4_checksum = nat_pkg::csum_adj16(in_q.l4_checksum, in_q.inner_checksum,
                                                     res_q.new_inner_checksum);
        state_d = S_CS3;
      end
      S_CS3: begin
        res_d.new_l4_checksum = nat_pkg::csum_adj(res_q.new_l4_checksum, inner_old, innew_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d            = res_q;
          out_d.drop_total = drop_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (start) begin
      key_d   = skey;
      addr_d  = hash_idx(skey);
      exam_d  = '0;
      pend_d  = 1'b0;
      purp_d  = spurp;
      state_d = S_PROBE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      purp_q      <= P_ADD_A;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      purp_q      <= purp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    res_q   <= res_d;
    out_q   <= out_d;
    key_q   <= key_d;
    addr_q  <= addr_d;
    pa_q    <= pa_d;
    exam_q  <= exam_d;
    ha_q    <= ha_d;
    hb_q    <= hb_d;
    sa_q    <= sa_d;
    newa_q  <= newa_d;
    innew_q <= innew_d;
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !req_i.ready)
    else $error("input ready during clearing pass");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (IW+1)'(TABLE_ENTRIES))
    else $error("rule count beyond table size");

  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q != $past(drop_q) |-> drop_q == $past(drop_q) + 32'd1)
    else $error("drop counter moved by more than one");

  a_result_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && (!out_valid_q || rsp_o.ready) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not loaded");
endmodule

FILE: sim/tb_top.sv
// Self-checking bench for the static IPv4 NAT engine: directed table, random traffic, table fill.
// Depends on nat_pkg, nat_stream_if and nat_address_rewrite_engine from the hdl folder.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned ENTRIES   = 1024;
  localparam int unsigned CYCLE_CAP = 20000000;

  typedef struct {
    nat_pkg::req_t rq;
    bit            typed;
    logic [1:0]    st;
    logic [31:0]   drops;
  } row_t;

  logic clk_i;
  logic rst_ni;

  nat_stream_if #(.T(nat_pkg::req_t)) req_if ();
  nat_stream_if #(.T(nat_pkg::rsp_t)) rsp_if ();

  nat_address_rewrite_engine #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [31:0]   nat_map [logic [31:0]];
  logic [31:0]   key_list [$];
  logic [31:0]   drop_cnt;
  nat_pkg::rsp_t rsp_pending [$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   src_idle;
  int unsigned   snk_idle;
  bit            hold_go;
  bit            saw_full;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] fold32(logic [15:0] hc, logic [31:0] ow, logic [31:0] nw);
    logic [31:0] s;
    s = {16'h0, ~hc} + {16'h0, ~ow[31:16]} + {16'h0, ~ow[15:0]} + {16'h0, nw[31:16]}
        + {16'h0, nw[15:0]};
    s = (s & 32'hffff) + (s >> 16);
    s = (s & 32'hffff) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic logic [15:0] fold16(logic [15:0] hc, logic [15:0] oh, logic [15:0] nh);
    logic [31:0] s;
    s = {16'h0, ~hc} + {16'h0, ~oh} + {16'h0, nh};
    s = (s & 32'hffff) + (s >> 16);
    s = (s & 32'hffff) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic nat_pkg::rsp_t echo(nat_pkg::req_t r, logic [1:0] st,
                                         logic [31:0] drops);
    nat_pkg::rsp_t e;
    e.status                = st;
    e.new_source            = r.addr_a;
    e.new_destination       = r.addr_b;
    e.new_ip_checksum       = r.ip_checksum;
    e.new_l4_checksum       = r.l4_checksum;
    e.offload_request       = nat_pkg::OFF_NONE;
    e.new_inner_source      = r.inner_source;
    e.new_inner_destination = r.inner_destination;
    e.new_inner_checksum    = r.inner_checksum;
    e.drop_total            = drops;
    return e;
  endfunction

  function automatic void learn(logic [31:0] k, logic [31:0] v);
    if (!nat_map.exists(k)) key_list.push_back(k);
    nat_map[k] = v;
  endfunction

  // Rewrite one item against the shadow rule table and drop counter.
  function automatic nat_pkg::rsp_t rewrite_item(nat_pkg::req_t r);
    nat_pkg::rsp_t e;
    nat_pkg::rsp_t t;
    int unsigned   need;
    logic [31:0]   oldad;
    logic [31:0]   newad;
    logic [31:0]   iold;
    logic [31:0]   inew;
    bit            later;
    bit            drop;
    e = echo(r, nat_pkg::ST_OK, drop_cnt);
    if (r.op == nat_pkg::OP_ADD) begin
      need = (nat_map.exists(r.addr_a) ? 0 : 1) +
             ((r.addr_a != r.addr_b && !nat_map.exists(r.addr_b)) ? 1 : 0);
      if (ENTRIES - nat_map.num() < need) begin
        e.status = nat_pkg::ST_FULL;
        saw_full = 1'b1;
      end else begin
        learn(r.addr_a, r.addr_b);
        if (r.addr_a != r.addr_b) learn(r.addr_b, r.addr_a);
      end
    end else if (r.op == nat_pkg::OP_XSRC || r.op == nat_pkg::OP_XDST) begin
      oldad = (r.op == nat_pkg::OP_XSRC) ? r.addr_a : r.addr_b;
      if (!nat_map.exists(oldad)) begin
        drop_cnt++;
        e.status = nat_pkg::ST_DROP;
      end else begin
        newad = nat_map[oldad];
        later = (r.fragment_kind >= nat_pkg::FRAG_LATER);
        drop  = 1'b0;
        t = e;
        if (r.op == nat_pkg::OP_XSRC) t.new_source = newad;
        else t.new_destination = newad;
        t.new_ip_checksum = fold32(r.ip_checksum, oldad, newad);
        if (!later && (r.protocol == nat_pkg::PROTO_TCP || r.protocol == nat_pkg::PROTO_UDP ||
                       r.protocol == nat_pkg::PROTO_UDPLITE)) begin
          if (r.fragment_kind == nat_pkg::FRAG_FIRST) begin
            t.new_l4_checksum = fold32(r.l4_checksum, oldad, newad);
          end else begin
            t.new_l4_checksum = 16'h0;
            t.offload_request = (r.protocol == nat_pkg::PROTO_TCP) ?
                                nat_pkg::OFF_TCP : nat_pkg::OFF_UDP;
          end
        end else if (!later && r.protocol == nat_pkg::PROTO_ICMP &&
                     (r.icmp_kind == nat_pkg::ICMP_UNREACH ||
                      r.icmp_kind == nat_pkg::ICMP_TIMEX ||
                      r.icmp_kind == nat_pkg::ICMP_PARAMPRB)) begin
          if (r.outer_length < nat_pkg::ICMP_MIN_LEN) begin
            t.status = nat_pkg::ST_SHORT;
          end else begin
            iold = (r.op == nat_pkg::OP_XSRC) ? r.inner_destination : r.inner_source;
            if (!nat_map.exists(iold)) begin
              drop = 1'b1;
            end else begin
              inew = nat_map[iold];
              if (r.op == nat_pkg::OP_XSRC) t.new_inner_destination = inew;
              else t.new_inner_source = inew;
              t.new_inner_checksum = fold32(r.inner_checksum, iold, inew);
              t.new_l4_checksum = fold16(r.l4_checksum, r.inner_checksum,
                                         t.new_inner_checksum);
              t.new_l4_checksum = fold32(t.new_l4_checksum, iold, inew);
            end
          end
        end
        if (drop) begin
          drop_cnt++;
          e.status = nat_pkg::ST_DROP;
        end else begin
          e = t;
        end
      end
      e.drop_total = drop_cnt;
    end
    return e;
  endfunction

  function automatic nat_pkg::req_t mk(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                                       logic [7:0] pr, logic [1:0] fk, logic [15:0] ipc,
                                       logic [15:0] l4c, logic [7:0] ik, logic [15:0] tl,
                                       logic [31:0] isrc, logic [31:0] idst,
                                       logic [15:0] ic);
    nat_pkg::req_t r;
    r.op = op; r.addr_a = a; r.addr_b = b; r.protocol = pr; r.fragment_kind = fk;
    r.ip_checksum = ipc; r.l4_checksum = l4c; r.icmp_kind = ik; r.outer_length = tl;
    r.inner_source = isrc; r.inner_destination = idst; r.inner_checksum = ic;
    return r;
  endfunction

  function automatic logic [31:0] pick_addr(int unsigned known_pct);
    if (key_list.size() != 0 && $urandom_range(99) < known_pct)
      return key_list[$urandom_range(key_list.size() - 1)];
    return $urandom();
  endfunction

  function automatic nat_pkg::req_t rand_any();
    return mk(2'($urandom_range(3)), $urandom(), $urandom(), 8'($urandom()),
              2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()), 8'($urandom()),
              16'($urandom()), $urandom(), $urandom(), 16'($urandom()));
  endfunction

  function automatic nat_pkg::req_t rand_item(int unsigned add_pct);
    nat_pkg::req_t r;
    int unsigned   k;
    r = mk(2'($urandom_range(1, 2)), pick_addr(85), pick_addr(85), 8'($urandom()),
           2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()), 8'($urandom()),
           16'($urandom()), pick_addr(80), pick_addr(80), 16'($urandom()));
    k = $urandom_range(99);
    if (k < add_pct) begin
      r.op = nat_pkg::OP_ADD;
      r.addr_a = pick_addr(20);
      r.addr_b = ($urandom_range(19) == 0) ? r.addr_a : pick_addr(20);
    end else if (k < add_pct + 3) begin
      r.op = nat_pkg::OP_RSVD;
    end
    case ($urandom_range(5))
      0: r.protocol = nat_pkg::PROTO_TCP;
      1: r.protocol = nat_pkg::PROTO_UDP;
      2: r.protocol = nat_pkg::PROTO_UDPLITE;
      3, 4: r.protocol = nat_pkg::PROTO_ICMP;
      default: ;
    endcase
    case ($urandom_range(4))
      0: r.icmp_kind = nat_pkg::ICMP_UNREACH;
      1: r.icmp_kind = nat_pkg::ICMP_TIMEX;
      2: r.icmp_kind = nat_pkg::ICMP_PARAMPRB;
      default: ;
    endcase
    if ($urandom_range(5) == 0) r.outer_length = 16'($urandom_range(0, 60));
    if ($urandom_range(2) != 0) r.fragment_kind = 2'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic send(nat_pkg::req_t r, bit typed, logic [1:0] st, logic [31:0] drops);
    nat_pkg::rsp_t e;
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    e = rewrite_item(r);
    rsp_pending.push_back(typed ? echo(r, st, drops) : e);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = 600;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    nat_pkg::rsp_t g;
    nat_pkg::rsp_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("nat_address_rewrite_engine verification failed");
      $finish;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      g = rsp_if.data;
      if (rsp_pending.size() == 0) begin
        report("unexpected transfer", 32'h0, 32'h0);
      end else begin
        w = rsp_pending.pop_front();
        if (g.status !== w.status) report("status", 32'(g.status), 32'(w.status));
        if (g.new_source !== w.new_source) report("new_source", g.new_source, w.new_source);
        if (g.new_destination !== w.new_destination)
          report("new_destination", g.new_destination, w.new_destination);
        if (g.new_ip_checksum !== w.new_ip_checksum)
          report("new_ip_checksum", 32'(g.new_ip_checksum), 32'(w.new_ip_checksum));
        if (g.new_l4_checksum !== w.new_l4_checksum)
          report("new_l4_checksum", 32'(g.new_l4_checksum), 32'(w.new_l4_checksum));
        if (g.offload_request !== w.offload_request)
          report("offload_request", 32'(g.offload_request), 32'(w.offload_request));
        if (g.new_inner_source !== w.new_inner_source)
          report("new_inner_source", g.new_inner_source, w.new_inner_source);
        if (g.new_inner_destination !== w.new_inner_destination)
          report("new_inner_destination", g.new_inner_destination, w.new_inner_destination);
        if (g.new_inner_checksum !== w.new_inner_checksum)
          report("new_inner_checksum", 32'(g.new_inner_checksum), 32'(w.new_inner_checksum));
        if (g.drop_total !== w.drop_total)
          report("drop_total", g.drop_total, w.drop_total);
      end
    end
  end

  initial begin
    row_t        rows [$];
    row_t        rw;
    int unsigned ph;
    int unsigned n;
    int unsigned after_full;
    drop_cnt = 32'h0;
    saw_full = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    hold_go  = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: typed rows carry status and drop count, others use the predictor.
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0, 32'h01020304, nat_pkg::PROTO_TCP,
                        nat_pkg::FRAG_NONE, 16'h1234, 16'h5678, 8'd0, 16'd60, 32'h0, 32'h0,
                        16'h0), 1'b1, nat_pkg::ST_DROP, 32'd1});
    rows.push_back('{mk(nat_pkg::OP_XDST, 32'h05060708, 32'hffffffff, nat_pkg::PROTO_UDP,
                        nat_pkg::FRAG_FIRST, 16'hffff, 16'hffff, 8'hff, 16'hffff,
                        32'hffffffff, 32'hffffffff, 16'hffff),
                     1'b1, nat_pkg::ST_DROP, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_RSVD, 32'h0a000001, 32'h0a000002, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_NONE, 16'h0, 16'h0, nat_pkg::ICMP_UNREACH, 16'd20,
                        32'h1, 32'h2, 16'h3), 1'b1, nat_pkg::ST_OK, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_ADD, 32'h0a000001, 32'hc0a80001, 8'd0, nat_pkg::FRAG_NONE,
                        16'h0, 16'h0, 8'd0, 16'd0, 32'h0, 32'h0, 16'h0),
                     1'b1, nat_pkg::ST_OK, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_ADD, 32'hffffffff, 32'hffffffff, 8'hff, nat_pkg::FRAG_RSVD,
                        16'hffff, 16'hffff, 8'hff, 16'hffff, 32'hffffffff, 32'hffffffff,
                        16'hffff), 1'b1, nat_pkg::ST_OK, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_ADD, 32'h0, 32'hc0a80002, 8'd0, nat_pkg::FRAG_NONE, 16'h0,
                        16'h0, 8'd0, 16'd0, 32'h0, 32'h0, 16'h0),
                     1'b1, nat_pkg::ST_OK, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_ADD, 32'h0a000001, 32'hc0a80003, 8'd0, nat_pkg::FRAG_NONE,
                        16'h0, 16'h0, 8'd0, 16'd0, 32'h0, 32'h0, 16'h0),
                     1'b1, nat_pkg::ST_OK, 32'd2});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h08080808, nat_pkg::PROTO_TCP,
                        nat_pkg::FRAG_NONE, 16'hb1e6, 16'h4c21, 8'd0, 16'd40, 32'h0, 32'h0,
                        16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h08080808, nat_pkg::PROTO_UDP,
                        nat_pkg::FRAG_FIRST, 16'hffff, 16'h0, 8'd0, 16'd1500, 32'h0, 32'h0,
                        16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XDST, 32'h08080808, 32'hc0a80003, nat_pkg::PROTO_UDPLITE,
                        nat_pkg::FRAG_NONE, 16'h0, 16'hffff, 8'd0, 16'd100, 32'h0, 32'h0,
                        16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'hffffffff, 32'h0, nat_pkg::PROTO_TCP,
                        nat_pkg::FRAG_LATER, 16'h7fff, 16'h8000, 8'd0, 16'd100, 32'h0, 32'h0,
                        16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0, 32'h1, nat_pkg::PROTO_UDP, nat_pkg::FRAG_RSVD,
                        16'h8000, 16'h7fff, 8'd0, 16'd100, 32'h0, 32'h0, 16'h0),
                     1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h1, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_NONE, 16'h1111, 16'h2222, 8'd0, 16'd84, 32'h0, 32'h0,
                        16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h1, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_NONE, 16'h1111, 16'h2222, nat_pkg::ICMP_UNREACH, 16'd47,
                        32'h1, 32'hc0a80002, 16'h3333), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h1, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_NONE, 16'h1111, 16'h2222, nat_pkg::ICMP_TIMEX, 16'd48,
                        32'h1, 32'hc0a80002, 16'h3333), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XDST, 32'h1, 32'hc0a80001, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_FIRST, 16'hfffe, 16'h0001, nat_pkg::ICMP_PARAMPRB,
                        16'hffff, 32'h0, 32'h9, 16'hffff), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0a000001, 32'h1, nat_pkg::PROTO_ICMP,
                        nat_pkg::FRAG_NONE, 16'h1111, 16'h2222, nat_pkg::ICMP_UNREACH, 16'd56,
                        32'h1, 32'h77777777, 16'h3333), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XSRC, 32'h0, 32'h0, 8'hff, nat_pkg::FRAG_NONE, 16'h0, 16'h0,
                        8'd0, 16'd0, 32'h0, 32'h0, 16'h0), 1'b0, nat_pkg::ST_OK, 32'd0});
    rows.push_back('{mk(nat_pkg::OP_XDST, 32'hffffffff, 32'h0, 8'hff, nat_pkg::FRAG_FIRST,
                        16'hffff, 16'hffff, 8'hff, 16'hffff, 32'hffffffff, 32'hffffffff,
                        16'hffff), 1'b0, nat_pkg::ST_OK, 32'd0});
    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.rq, rw.typed, rw.st, rw.drops);
    end

    // Random traffic over the idling phases; long hold-off in the first.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 61; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 61; end
        default: begin src_idle = 37; snk_idle = 37; end
      endcase
      for (n = 0; n < 180; n++) begin
        if (ph == 0 && n == 40) hold_go = 1'b1;
        send(rand_item(20), 1'b0, nat_pkg::ST_OK, 32'd0);
      end
    end

    // Fill the table until it reports full, then keep mixing.
    src_idle = 10;
    snk_idle = 10;
    after_full = 0;
    while (after_full < 40) begin
      if (saw_full) begin
        after_full++;
        send(rand_item(40), 1'b0, nat_pkg::ST_OK, 32'd0);
      end else begin
        rw.rq = rand_any();
        rw.rq.op = nat_pkg::OP_ADD;
        send(rw.rq, 1'b0, nat_pkg::ST_OK, 32'd0);
      end
    end
    req_if.valid <= 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("nat_address_rewrite_engine verification clean");
    end else begin
      $display("nat_address_rewrite_engine verification failed");
    end
    $finish;
  end

endmodule
